// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PRIO_W      = 16;
    localparam int VALUE_W     = 32;
    localparam int OCC_W       = 5;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PRIO_W-1:0]         prio;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_PUSH,
        CMD_POP
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_ZERO_PRIO = 2'd3
    } status_t;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: keeps, inserts, or shifts its entry.
module spq_cell
    import spq_pkg::*;
(
    input  logic   clk,
    input  cmd_t   cmd,
    input  entry_t new_entry,
    input  entry_t left_entry,
    input  logic   left_keep,
    input  entry_t right_entry,
    input  logic   occupied,
    output entry_t entry,
    output logic   keep
);

    entry_t entry_reg;
    entry_t entry_next;

    // entry stays in place if it is at least as urgent as the new one
    assign keep  = occupied && (entry_reg.prio <= new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd)
            CMD_PUSH:
            begin
                if (keep)
                begin
                    entry_next = entry_reg;
                end
                else if (left_keep)
                begin
                    entry_next = new_entry;
                end
                else
                begin
                    entry_next = left_entry;
                end
            end
            CMD_POP:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue top level: request handling, count and result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries mode, value, priority_req.
//   mode 0 pushes value with priority_req (1 most urgent); mode 1 pops the
//   head. Entries of equal priority leave in arrival order.
//   Output channel (out_valid / out_stall) returns one transaction per
//   request: popped_value, status (ok, empty, full, zero priority) and
//   occupancy after the request.
//   out_valid rises in the cycle after input acceptance. Throughput is
//   one transaction per cycle while out_stall does not hold a result: the
//   chain of slots inserts or removes an entry all at once, every slot
//   comparing against the new priority in parallel.
//   A result held by out_stall blocks the next request (in_stall follows
//   out_valid && out_stall); a result being taken frees the register for a
//   new request in the same cycle.
//   Reset empties the queue and clears out_valid; slot contents are not
//   cleared and are only read below the stored count.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      mode,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [PRIO_W-1:0]         priority_req,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] popped_value,
    output logic [1:0]                status,
    output logic [OCC_W-1:0]          occupancy
);

    logic                      in_accept;
    cmd_t                      cmd;
    entry_t                    new_entry;
    entry_t                    cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]    cell_keep;
    logic [QUEUE_DEPTH-1:0]    occupied;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [VALUE_W-1:0] popped_value_reg;
    logic signed [VALUE_W-1:0] popped_value_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic [OCC_W-1:0]          occupancy_reg;
    logic [OCC_W-1:0]          occupancy_next;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign new_entry.prio  = priority_req;
    assign new_entry.value = value;

    always_comb
    begin
        cmd               = CMD_HOLD;
        status_next       = ST_OK;
        popped_value_next = '0;
        count_next        = count_reg;
        if (mode_t'(mode) == MODE_PUSH)
        begin
            priority if (priority_req == '0)
            begin
                status_next = ST_ZERO_PRIO;
            end
            else if (count_reg >= CNT_W'(QUEUE_DEPTH))
            begin
                status_next = ST_FULL;
            end
            else
            begin
                cmd        = CMD_PUSH;
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                cmd               = CMD_POP;
                popped_value_next = cell_entry[0].value;
                count_next        = count_reg - CNT_W'(1);
            end
        end
        if (!in_accept)
        begin
            cmd        = CMD_HOLD;
            count_next = count_reg;
        end
        occupancy_next = OCC_W'(count_next);
        out_valid_next = in_accept || (out_valid_reg && out_stall);
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            entry_t left_entry;
            entry_t right_entry;
            logic   left_keep;

            assign occupied[i] = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_head
                assign left_entry = new_entry;
                assign left_keep  = 1'b1;
            end
            else
            begin : g_body
                assign left_entry = cell_entry[i-1];
                assign left_keep  = cell_keep[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_entry = new_entry;
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .new_entry   (new_entry),
                .left_entry  (left_entry),
                .left_keep   (left_keep),
                .right_entry (right_entry),
                .occupied    (occupied[i]),
                .entry       (cell_entry[i]),
                .keep        (cell_keep[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            popped_value_reg <= popped_value_next;
            status_reg       <= status_next;
            occupancy_reg    <= occupancy_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_value_reg;
    assign status       = status_reg;
    assign occupancy    = occupancy_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("stored count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_PUSH) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not add an entry");

    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && status_next != ST_OK) |=> $stable(count_reg))
        else $error("rejected transaction changed the count");

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_POP) |=> popped_value == $past(cell_entry[0].value))
        else $error("pop did not return the head entry");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> cell_entry[0].prio <= cell_entry[1].prio)
        else $error("head entry less urgent than its successor");

endmodule
